FILE: rtl/core/tcpd_pkg.sv
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared constants, types and helpers of the text code page detector.
// ----------------------------------------------------------------------------
package tcpd_pkg;

	localparam int COUNT_WIDTH = 32;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	// encoding codes of a result beat
	localparam logic [2:0] ENC_UTF16LE = 3'd0;
	localparam logic [2:0] ENC_UTF8    = 3'd1;
	localparam logic [2:0] ENC_SJIS    = 3'd2;
	localparam logic [2:0] ENC_CP949   = 3'd3;
	localparam logic [2:0] ENC_DEFAULT = 3'd4;

	// prefix skip codes
	localparam logic [1:0] SKIP_NONE = 2'd0;
	localparam logic [1:0] SKIP_BOM16 = 2'd2;
	localparam logic [1:0] SKIP_BOM8 = 2'd3;

	// byte-order mark bytes
	localparam logic [7:0] BOM16_B0 = 8'hFF;
	localparam logic [7:0] BOM16_B1 = 8'hFE;
	localparam logic [7:0] BOM8_B0 = 8'hEF;
	localparam logic [7:0] BOM8_B1 = 8'hBB;
	localparam logic [7:0] BOM8_B2 = 8'hBF;

	typedef struct packed {
		logic ok;
		cnt_t score;
	} utf8_res_t;

	typedef struct packed {
		logic bad;
		cnt_t pairs;
		cnt_t kana;
	} sjis_res_t;

	typedef struct packed {
		logic bad;
		cnt_t pairs;
	} cp949_res_t;

	// end-of-buffer snapshot handed to the decision stage
	typedef struct packed {
		logic       bom16;
		logic       bom8;
		utf8_res_t  utf8;
		sjis_res_t  sjis;
		cp949_res_t cp949;
	} snap_t;

	function automatic cnt_t sat_add(cnt_t a, logic [2:0] n);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + (COUNT_WIDTH+1)'(n);
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

endpackage

FILE: rtl/core/tcpd_if.sv
// ----------------------------------------------------------------------------
// tcpd_byte_if / tcpd_result_if
// Valid/ready channels of the detector: input bytes and result beats.
// ----------------------------------------------------------------------------
interface tcpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tcpd_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] encoding;
	logic [1:0] prefix_skip;

	modport source (output valid, output encoding, output prefix_skip, input ready);
	modport sink (input valid, input encoding, input prefix_skip, output ready);
endinterface

FILE: rtl/core/tcpd_utf8_check.sv
// ----------------------------------------------------------------------------
// tcpd_utf8_check
// UTF-8 structure check with overlong/surrogate/range limits and a score.
// ----------------------------------------------------------------------------
module tcpd_utf8_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output tcpd_pkg::utf8_res_t res
);
	import tcpd_pkg::*;

	logic       ok_q;
	logic [7:0] lead_q;
	logic [1:0] left_q;
	logic       second_q;
	cnt_t       score_q;

	logic       ok_d;
	logic [7:0] lead_d;
	logic [1:0] left_d;
	logic       second_d;
	cnt_t       score_d;
	logic [2:0] seq_len;

	assign seq_len = (lead_q >= 8'hF0) ? 3'd4 : ((lead_q >= 8'hE0) ? 3'd3 : 3'd2);

	always_comb begin
		ok_d     = ok_q;
		lead_d   = lead_q;
		left_d   = left_q;
		second_d = second_q;
		score_d  = score_q;
		if (ok_q) begin
			if (left_q == 2'd0) begin
				if (data_byte >= 8'h80) begin
					lead_d   = data_byte;
					second_d = 1'b1;
					if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
						left_d = 2'd1;
					end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
						left_d = 2'd2;
					end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
						left_d = 2'd3;
					end else begin
						ok_d     = 1'b0;
						lead_d   = lead_q;
						second_d = second_q;
					end
				end
			end else begin
				if (data_byte[7:6] != 2'b10) begin
					ok_d = 1'b0;
				end
				if (second_q) begin
					// overlong, surrogate and above-U+10FFFF forms
					if ((lead_q == 8'hE0 && data_byte < 8'hA0) ||
					    (lead_q == 8'hED && data_byte >= 8'hA0) ||
					    (lead_q == 8'hF0 && data_byte < 8'h90) ||
					    (lead_q == 8'hF4 && data_byte >= 8'h90)) begin
						ok_d = 1'b0;
					end
					second_d = 1'b0;
				end
				left_d = left_q - 2'd1;
				if (left_q == 2'd1) begin
					score_d = sat_add(score_q, seq_len);
				end
			end
		end
	end

	// an unfinished sequence at the end fails the check
	assign res.ok    = ok_d && (left_d == 2'd0);
	assign res.score = score_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q     <= 1'b1;
			lead_q   <= '0;
			left_q   <= '0;
			second_q <= 1'b0;
			score_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				ok_q     <= 1'b1;
				lead_q   <= '0;
				left_q   <= '0;
				second_q <= 1'b0;
				score_q  <= '0;
			end else begin
				ok_q     <= ok_d;
				lead_q   <= lead_d;
				left_q   <= left_d;
				second_q <= second_d;
				score_q  <= score_d;
			end
		end
	end

endmodule

FILE: rtl/core/tcpd_sjis_check.sv
// ----------------------------------------------------------------------------
// tcpd_sjis_check
// Shift-JIS pair and half-width kana counting with an invalid-byte flag.
// ----------------------------------------------------------------------------
module tcpd_sjis_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output tcpd_pkg::sjis_res_t res
);
	import tcpd_pkg::*;

	logic open_q;
	logic bad_q;
	cnt_t pairs_q;
	cnt_t kana_q;

	logic open_d;
	logic bad_d;
	cnt_t pairs_d;
	cnt_t kana_d;
	logic trail_ok;

	assign trail_ok = (data_byte >= 8'h40 && data_byte <= 8'h7E) ||
	                  (data_byte >= 8'h80 && data_byte <= 8'hFC);

	always_comb begin
		open_d  = 1'b0;
		bad_d   = bad_q;
		pairs_d = pairs_q;
		kana_d  = kana_q;
		if (open_q && trail_ok) begin
			pairs_d = sat_add(pairs_q, 3'd1);
		end else begin
			// a bad trail flags the lead, then the byte is taken afresh
			if (open_q) begin
				bad_d = 1'b1;
			end
			if (data_byte >= 8'h80) begin
				if (data_byte >= 8'hA1 && data_byte <= 8'hDF) begin
					kana_d = sat_add(kana_q, 3'd1);
				end else if ((data_byte >= 8'h81 && data_byte <= 8'h9F) ||
				             (data_byte >= 8'hE0 && data_byte <= 8'hFC)) begin
					open_d = 1'b1;
				end else begin
					bad_d = 1'b1;
				end
			end
		end
	end

	assign res.bad   = bad_d || open_d;
	assign res.pairs = pairs_d;
	assign res.kana  = kana_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			bad_q   <= 1'b0;
			pairs_q <= '0;
			kana_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				open_q  <= 1'b0;
				bad_q   <= 1'b0;
				pairs_q <= '0;
				kana_q  <= '0;
			end else begin
				open_q  <= open_d;
				bad_q   <= bad_d;
				pairs_q <= pairs_d;
				kana_q  <= kana_d;
			end
		end
	end

endmodule

FILE: rtl/core/tcpd_cp949_check.sv
// ----------------------------------------------------------------------------
// tcpd_cp949_check
// CP949 pair counting with an invalid-byte flag.
// ----------------------------------------------------------------------------
module tcpd_cp949_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output tcpd_pkg::cp949_res_t res
);
	import tcpd_pkg::*;

	logic open_q;
	logic bad_q;
	cnt_t pairs_q;

	logic open_d;
	logic bad_d;
	cnt_t pairs_d;
	logic trail_ok;

	assign trail_ok = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
	                  (data_byte >= 8'h61 && data_byte <= 8'h7A) ||
	                  (data_byte >= 8'h81 && data_byte <= 8'hFE);

	always_comb begin
		open_d  = 1'b0;
		bad_d   = bad_q;
		pairs_d = pairs_q;
		if (open_q && trail_ok) begin
			pairs_d = sat_add(pairs_q, 3'd1);
		end else begin
			if (open_q) begin
				bad_d = 1'b1;
			end
			if (data_byte >= 8'h80) begin
				if (data_byte >= 8'h81 && data_byte <= 8'hFE) begin
					open_d = 1'b1;
				end else begin
					bad_d = 1'b1;
				end
			end
		end
	end

	assign res.bad   = bad_d || open_d;
	assign res.pairs = pairs_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			bad_q   <= 1'b0;
			pairs_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				open_q  <= 1'b0;
				bad_q   <= 1'b0;
				pairs_q <= '0;
			end else begin
				open_q  <= open_d;
				bad_q   <= bad_d;
				pairs_q <= pairs_d;
			end
		end
	end

endmodule

FILE: rtl/core/tcpd_decide.sv
// ----------------------------------------------------------------------------
// tcpd_decide
// Picks the encoding and prefix skip from an end-of-buffer snapshot.
// ----------------------------------------------------------------------------
module tcpd_decide (
	input  tcpd_pkg::snap_t snap,
	output logic [2:0]      encoding,
	output logic [1:0]      prefix_skip
);
	import tcpd_pkg::*;

	localparam int SW = COUNT_WIDTH + 2;

	logic [SW-1:0] score_x;
	logic [SW-1:0] lim_sjis;
	logic [SW-1:0] lim_kor;
	logic          score_wins;
	logic          score_nz;
	logic          sjis_seen;
	logic          kor_seen;

	assign score_x  = SW'(snap.utf8.score);
	// score > 2*pairs + kana + 1 and score > korean pairs + 1
	assign lim_sjis = SW'({snap.sjis.pairs, 1'b0}) + SW'(snap.sjis.kana) + SW'(1);
	assign lim_kor  = SW'(snap.cp949.pairs) + SW'(1);
	assign score_wins = (score_x > lim_sjis) && (score_x > lim_kor);

	assign score_nz  = (snap.utf8.score != '0);
	assign sjis_seen = (snap.sjis.pairs != '0) || (snap.sjis.kana != '0);
	assign kor_seen  = (snap.cp949.pairs != '0);

	always_comb begin
		prefix_skip = SKIP_NONE;
		encoding    = ENC_DEFAULT;
		if (snap.bom16) begin
			prefix_skip = SKIP_BOM16;
			encoding    = ENC_UTF16LE;
		end else if (snap.bom8) begin
			prefix_skip = SKIP_BOM8;
			encoding    = ENC_UTF8;
		end else if (snap.utf8.ok && snap.sjis.bad && snap.cp949.bad) begin
			encoding = ENC_UTF8;
		end else if (snap.utf8.ok && !sjis_seen && !kor_seen && score_nz) begin
			encoding = ENC_UTF8;
		end else if (snap.utf8.ok && score_wins) begin
			encoding = ENC_UTF8;
		end else if (!snap.sjis.bad && sjis_seen) begin
			encoding = ENC_SJIS;
		end else if (!snap.cp949.bad && kor_seen) begin
			encoding = ENC_CP949;
		end else if (snap.utf8.ok && score_nz) begin
			encoding = ENC_UTF8;
		end
	end

endmodule

FILE: rtl/core/text_code_page_detector_core.sv
// ----------------------------------------------------------------------------
// text_code_page_detector_core
// Byte-stream code page detector: UTF-8, Shift-JIS, CP949 and BOM checks.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one buffer byte per beat; last_byte marks the final beat
//   of a buffer. result_out carries one beat per buffer: the detected
//   encoding (UTF-16LE, UTF-8, Shift-JIS, CP949 or system default) and the
//   byte-order mark length to skip.
// Throughput: one byte per clock while result_out.ready is high, including buffer ends.
// Pipeline: a byte is registered in stage 1; the three checkers update from
//   stage 1. On the last beat their final status is captured in stage 2, and
//   the decision (two wide add-and-compare paths on the score counters) is
//   registered into the result register.
// Stalls: the result register is held while result_out.ready is low. The
//   stage 2 snapshot and stage 1 then fill; bytes that are not last keep
//   flowing through stage 1, so byte_in only backs up once a second last
//   byte meets a full snapshot stage.
// Reset: arst_n clears all checker state, the header capture and the
//   pipeline valids. After each last byte the checkers return to that same
//   state, so the next byte opens a new buffer.
// ----------------------------------------------------------------------------
module text_code_page_detector_core (
	input  logic          clk,
	input  logic          arst_n,
	tcpd_byte_if.sink     byte_in,
	tcpd_result_if.source result_out
);
	import tcpd_pkg::*;

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// stage 2: end-of-buffer snapshot
	logic  valid_s2;
	snap_t snap_s2;

	// result register
	logic       res_valid_q;
	logic [2:0] encoding_q;
	logic [1:0] skip_q;

	// first three bytes of the buffer, first byte in bits 7:0
	logic [23:0] head_bytes_q;
	logic [1:0]  head_count_q;
	logic [23:0] head_bytes_d;
	logic [1:0]  head_count_d;

	logic adv1;
	logic adv2;

	utf8_res_t  utf8_res;
	sjis_res_t  sjis_res;
	cp949_res_t cp949_res;
	snap_t      snap_d;
	logic [2:0] encoding_d;
	logic [1:0] skip_d;

	// result drains when the output is free or being taken
	assign adv2 = valid_s2 && (!res_valid_q || result_out.ready);
	// plain bytes never wait; a last byte needs room in the snapshot stage
	assign adv1 = valid_s1 && (!last_s1 || !valid_s2 || adv2);
	assign byte_in.ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	// header capture for byte-order mark detection
	always_comb begin
		head_bytes_d = head_bytes_q;
		head_count_d = head_count_q;
		if (head_count_q != 2'd3) begin
			head_bytes_d = head_bytes_q | (24'(byte_s1) << {head_count_q, 3'b000});
			head_count_d = head_count_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_bytes_q <= '0;
			head_count_q <= '0;
		end else if (adv1) begin
			if (last_s1) begin
				head_bytes_q <= '0;
				head_count_q <= '0;
			end else begin
				head_bytes_q <= head_bytes_d;
				head_count_q <= head_count_d;
			end
		end
	end

	tcpd_utf8_check u_utf8 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (utf8_res)
	);

	tcpd_sjis_check u_sjis (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (sjis_res)
	);

	tcpd_cp949_check u_cp949 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (cp949_res)
	);

	always_comb begin
		snap_d.bom16 = (head_count_d >= 2'd2) &&
		               (head_bytes_d[7:0] == BOM16_B0) && (head_bytes_d[15:8] == BOM16_B1);
		snap_d.bom8  = (head_count_d == 2'd3) &&
		               (head_bytes_d[7:0] == BOM8_B0) && (head_bytes_d[15:8] == BOM8_B1) &&
		               (head_bytes_d[23:16] == BOM8_B2);
		snap_d.utf8  = utf8_res;
		snap_d.sjis  = sjis_res;
		snap_d.cp949 = cp949_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			snap_s2 <= snap_d;
		end
	end

	tcpd_decide u_decide (
		.snap        (snap_s2),
		.encoding    (encoding_d),
		.prefix_skip (skip_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv2) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			encoding_q <= encoding_d;
			skip_q     <= skip_d;
		end
	end

	assign result_out.valid       = res_valid_q;
	assign result_out.encoding    = encoding_q;
	assign result_out.prefix_skip = skip_q;

`ifndef SYNTH
	// a byte that is not last never stalls in stage 1
	a_plain_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> adv1)
		else $error("non-last byte held in stage 1");

	// header capture restarts after every buffer end
	a_head_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && last_s1) |=> (head_count_q == 2'd0 && head_bytes_q == 24'd0))
		else $error("header capture not cleared at buffer end");

	// a mark skip always goes with its own encoding
	a_skip_enc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((skip_q == SKIP_NONE && encoding_q != ENC_UTF16LE) ||
		                 (skip_q == SKIP_BOM16 && encoding_q == ENC_UTF16LE) ||
		                 (skip_q == SKIP_BOM8 && encoding_q == ENC_UTF8)))
		else $error("prefix skip inconsistent with encoding");

	// a snapshot never gets overwritten before it drains
	a_snap_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && last_s1) |-> (!valid_s2 || adv2))
		else $error("snapshot overwritten");
`endif

endmodule

FILE: tb/sv/text_code_page_detector_core_tb.sv
// ----------------------------------------------------------------------------
// text_code_page_detector_core_tb
// Self-checking bench for the code page detector. Byte buffers go in on
// byte_in with random gaps. A scoreboard class holds its own model of the
// UTF-8, Shift-JIS and CP949 checkers and the BOM capture. It queues one
// expected encoding/prefix_skip pair per last byte and checks each result
// beat in order. The result side stalls at random, and once for a long
// stretch so that the pipeline backs up into byte_in.
// ----------------------------------------------------------------------------
module text_code_page_detector_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpd_pkg::*;

	localparam cnt_t CNT_FULL = '1;
	localparam int   RANDOM_BYTES = 1350;

	// one expected result beat
	typedef struct packed {
		logic [2:0] encoding;
		logic [1:0] prefix_skip;
	} code_page_result_t;

	// detector state as the bench tracks it between bytes
	typedef struct packed {
		logic [23:0] head;      // first three bytes, first one in [7:0]
		logic [1:0]  head_n;
		logic        u_ok;
		logic [7:0]  u_lead;
		logic [1:0]  u_left;    // continuation bytes still due
		logic        u_second;  // next byte is the first continuation
		cnt_t        u_score;
		logic        sj_open;
		cnt_t        sj_pairs;
		cnt_t        sj_kana;
		logic        sj_bad;
		logic        kr_open;
		cnt_t        kr_pairs;
		logic        kr_bad;
	} detector_state_t;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts per byte, checks per result beat
	// ------------------------------------------------------------------------
	class code_page_scoreboard;
		detector_state_t   st;
		code_page_result_t expected_q[$];
		int                failures;

		function new();
			failures = 0;
			clear_state();
		endfunction

		function void clear_state();
			st      = '0;
			st.u_ok = 1'b1;
		endfunction

		function cnt_t sat_inc(cnt_t a, cnt_t n);
			if (a > CNT_FULL - n)
				return CNT_FULL;
			return a + n;
		endfunction

		function void utf8_feed(logic [7:0] b);
			if (!st.u_ok)
				return;
			if (st.u_left == 0) begin
				if (b < 8'h80)
					return;
				if (b >= 8'hC2 && b <= 8'hDF)
					st.u_left = 2'd1;
				else if (b >= 8'hE0 && b <= 8'hEF)
					st.u_left = 2'd2;
				else if (b >= 8'hF0 && b <= 8'hF4)
					st.u_left = 2'd3;
				else begin
					st.u_ok = 1'b0;
					return;
				end
				st.u_lead   = b;
				st.u_second = 1'b1;
				return;
			end
			if (b[7:6] != 2'b10)
				st.u_ok = 1'b0;
			// overlong, surrogate and above-U+10FFFF limits sit on the 2nd byte
			if (st.u_second) begin
				if ((st.u_lead == 8'hE0 && b < 8'hA0) || (st.u_lead == 8'hED && b >= 8'hA0) ||
				    (st.u_lead == 8'hF0 && b < 8'h90) || (st.u_lead == 8'hF4 && b >= 8'h90))
					st.u_ok = 1'b0;
				st.u_second = 1'b0;
			end
			st.u_left = st.u_left - 2'd1;
			if (st.u_left == 0)
				st.u_score = sat_inc(st.u_score,
					st.u_lead >= 8'hF0 ? cnt_t'(4) : (st.u_lead >= 8'hE0 ? cnt_t'(3) : cnt_t'(2)));
		endfunction

		function void sjis_feed(logic [7:0] b);
			if (st.sj_open) begin
				st.sj_open = 1'b0;
				if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
					st.sj_pairs = sat_inc(st.sj_pairs, cnt_t'(1));
					return;
				end
				// bad trail: flag it, then treat the byte as fresh
				st.sj_bad = 1'b1;
			end
			if (b < 8'h80)
				return;
			if (b >= 8'hA1 && b <= 8'hDF)
				st.sj_kana = sat_inc(st.sj_kana, cnt_t'(1));
			else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC))
				st.sj_open = 1'b1;
			else
				st.sj_bad = 1'b1;
		endfunction

		function void korean_feed(logic [7:0] b);
			if (st.kr_open) begin
				st.kr_open = 1'b0;
				if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
				    (b >= 8'h81 && b <= 8'hFE)) begin
					st.kr_pairs = sat_inc(st.kr_pairs, cnt_t'(1));
					return;
				end
				st.kr_bad = 1'b1;
			end
			if (b < 8'h80)
				return;
			if (b >= 8'h81 && b <= 8'hFE)
				st.kr_open = 1'b1;
			else
				st.kr_bad = 1'b1;
		endfunction

		// score > 2*pairs + kana + 1 and score > korean pairs + 1, no overflow
		function logic utf8_outscores();
			cnt_t s1;
			if (st.u_score == 0)
				return 1'b0;
			s1 = st.u_score - cnt_t'(1);
			if (st.sj_pairs > (s1 >> 1))
				return 1'b0;
			if (s1 - (st.sj_pairs << 1) <= st.sj_kana)
				return 1'b0;
			return s1 > st.kr_pairs;
		endfunction

		function code_page_result_t decide();
			code_page_result_t r;
			logic [7:0] b0, b1, b2;
			b0 = st.head[7:0];
			b1 = st.head[15:8];
			b2 = st.head[23:16];
			r.prefix_skip = SKIP_NONE;
			r.encoding    = ENC_DEFAULT;
			if (st.head_n >= 2 && b0 == BOM16_B0 && b1 == BOM16_B1) begin
				r.encoding    = ENC_UTF16LE;
				r.prefix_skip = SKIP_BOM16;
			end else if (st.head_n == 3 && b0 == BOM8_B0 && b1 == BOM8_B1 && b2 == BOM8_B2) begin
				r.encoding    = ENC_UTF8;
				r.prefix_skip = SKIP_BOM8;
			end else if (st.u_ok && ((st.sj_bad && st.kr_bad) ||
			             (st.sj_pairs == 0 && st.sj_kana == 0 && st.kr_pairs == 0 &&
			              st.u_score != 0) || utf8_outscores()))
				r.encoding = ENC_UTF8;
			else if (!st.sj_bad && (st.sj_pairs != 0 || st.sj_kana != 0))
				r.encoding = ENC_SJIS;
			else if (!st.kr_bad && st.kr_pairs != 0)
				r.encoding = ENC_CP949;
			else if (st.u_ok && st.u_score != 0)
				r.encoding = ENC_UTF8;
			return r;
		endfunction

		// accepted byte beat
		function void note_byte(logic [7:0] b, logic last);
			if (st.head_n < 3) begin
				st.head[8*st.head_n +: 8] = b;
				st.head_n = st.head_n + 2'd1;
			end
			utf8_feed(b);
			sjis_feed(b);
			korean_feed(b);
			if (!last)
				return;
			// open leads at the end of the buffer
			if (st.sj_open)
				st.sj_bad = 1'b1;
			if (st.kr_open)
				st.kr_bad = 1'b1;
			if (st.u_left != 0)
				st.u_ok = 1'b0;
			expected_q.push_back(decide());
			clear_state();
		endfunction

		// accepted result beat
		function void check_result(logic [2:0] encoding, logic [1:0] prefix_skip);
			code_page_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: encoding %0d prefix_skip %0d",
					encoding, prefix_skip);
				failures++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (encoding !== exp_r.encoding) begin
				$error("encoding mismatch: expected %0d, actual %0d", exp_r.encoding, encoding);
				failures++;
			end
			if (prefix_skip !== exp_r.prefix_skip) begin
				$error("prefix_skip mismatch: expected %0d, actual %0d",
					exp_r.prefix_skip, prefix_skip);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	tcpd_byte_if   byte_if();
	tcpd_result_if result_if();

	text_code_page_detector_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_if),
		.result_out(result_if)
	);

	code_page_scoreboard sb = new();

	logic [7:0] text_q[$];          // buffer being sent
	int         bytes_accepted = 0;
	logic       tx_quiet = 1'b0;    // no sender gaps for this buffer
	logic       hold_off = 1'b0;    // long result-side stall in progress

	// ------------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------------
	function automatic logic [7:0] rnd8(int unsigned lo, int unsigned hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int tx_gap();
		if (tx_quiet || hold_off || $urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	// one UTF-8 character, with edge leads favored; now and then the second
	// byte ignores the lead's range, which probes the overlong and limit checks
	function automatic void add_utf8_char();
		logic [7:0] lead;
		logic       sloppy;
		sloppy = ($urandom_range(0, 9) == 0);
		case ($urandom_range(1, 4))
			1: text_q.push_back(rnd8(8'h00, 8'h7F));
			2: begin
				text_q.push_back(rnd8(8'hC2, 8'hDF));
				text_q.push_back(rnd8(8'h80, 8'hBF));
			end
			3: begin
				case ($urandom_range(0, 3))
					0: lead = 8'hE0;
					1: lead = 8'hED;
					default: lead = rnd8(8'hE0, 8'hEF);
				endcase
				text_q.push_back(lead);
				if (sloppy)
					text_q.push_back(rnd8(8'h80, 8'hBF));
				else if (lead == 8'hE0)
					text_q.push_back(rnd8(8'hA0, 8'hBF));
				else if (lead == 8'hED)
					text_q.push_back(rnd8(8'h80, 8'h9F));
				else
					text_q.push_back(rnd8(8'h80, 8'hBF));
				text_q.push_back(rnd8(8'h80, 8'hBF));
			end
			default: begin
				case ($urandom_range(0, 3))
					0: lead = 8'hF0;
					1: lead = 8'hF4;
					default: lead = rnd8(8'hF0, 8'hF4);
				endcase
				text_q.push_back(lead);
				if (sloppy)
					text_q.push_back(rnd8(8'h80, 8'hBF));
				else if (lead == 8'hF0)
					text_q.push_back(rnd8(8'h90, 8'hBF));
				else if (lead == 8'hF4)
					text_q.push_back(rnd8(8'h80, 8'h8F));
				else
					text_q.push_back(rnd8(8'h80, 8'hBF));
				text_q.push_back(rnd8(8'h80, 8'hBF));
				text_q.push_back(rnd8(8'h80, 8'hBF));
			end
		endcase
	endfunction

	function automatic void add_sjis_char();
		case ($urandom_range(0, 3))
			0: text_q.push_back(rnd8(8'h00, 8'h7F));
			1: text_q.push_back(rnd8(8'hA1, 8'hDF));   // half-width kana
			default: begin
				text_q.push_back($urandom_range(0, 1) ? rnd8(8'h81, 8'h9F) : rnd8(8'hE0, 8'hFC));
				text_q.push_back($urandom_range(0, 1) ? rnd8(8'h40, 8'h7E) : rnd8(8'h80, 8'hFC));
			end
		endcase
	endfunction

	function automatic void add_cp949_char();
		if ($urandom_range(0, 3) == 0) begin
			text_q.push_back(rnd8(8'h00, 8'h7F));
			return;
		end
		text_q.push_back(rnd8(8'h81, 8'hFE));
		case ($urandom_range(0, 2))
			0: text_q.push_back(rnd8(8'h41, 8'h5A));
			1: text_q.push_back(rnd8(8'h61, 8'h7A));
			default: text_q.push_back(rnd8(8'h81, 8'hFE));
		endcase
	endfunction

	// Mostly well-formed text of one flavor, some raw noise, an optional BOM,
	// and a few corrupted or truncated buffers.
	function automatic void make_random_text();
		int flavor;
		int n_chars;
		int r;
		text_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1)) begin
				text_q.push_back(BOM16_B0);
				text_q.push_back(BOM16_B1);
			end else begin
				text_q.push_back(BOM8_B0);
				text_q.push_back(BOM8_B1);
				text_q.push_back(BOM8_B2);
			end
		end
		flavor = $urandom_range(0, 9);
		r = $urandom_range(0, 19);
		n_chars = (r < 14) ? $urandom_range(1, 12) : (r < 19) ? $urandom_range(13, 30)
		                                                     : $urandom_range(40, 80);
		repeat (n_chars) begin
			case (flavor)
				0, 1, 2: add_utf8_char();
				3, 4:    add_sjis_char();
				5, 6:    add_cp949_char();
				7:       text_q.push_back(rnd8(8'h00, 8'hFF));
				8:       text_q.push_back(rnd8(8'h00, 8'h7F));
				default: begin
					case ($urandom_range(0, 2))
						0: add_utf8_char();
						1: add_sjis_char();
						default: add_cp949_char();
					endcase
				end
			endcase
		end
		if ($urandom_range(0, 6) == 0)
			text_q[$urandom_range(0, text_q.size() - 1)] = rnd8(8'h00, 8'hFF);
		// truncation can leave a lead open at the end
		if (text_q.size() > 1 && $urandom_range(0, 9) == 0)
			void'(text_q.pop_back());
	endfunction

	// ------------------------------------------------------------------------
	// Byte sender: valid stays high across back-to-back beats, so each step
	// sees a single nonblocking write to valid.
	// ------------------------------------------------------------------------
	task automatic send_text();
		int gap;
		logic is_last;
		foreach (text_q[i]) begin
			gap = tx_gap();
			if (gap > 0) begin
				byte_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			is_last = (i == text_q.size() - 1);
			byte_if.valid     <= 1'b1;
			byte_if.data_byte <= text_q[i];
			byte_if.last_byte <= is_last;
			do
				@(posedge clk);
			while (!byte_if.ready);
			sb.note_byte(text_q[i], is_last);
			bytes_accepted++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result sink: random stalls, quiet stretches, and the long hold-off
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int   stall;
		int   phase_left;
		logic quiet;
		stall      = 0;
		phase_left = 300;
		quiet      = 1'b0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				quiet      = ($urandom_range(0, 3) == 0);
				phase_left = $urandom_range(100, 500);
			end else
				phase_left--;
			if (hold_off)
				result_if.ready <= 1'b0;
			else if (stall > 0) begin
				stall--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 30)
					stall = idle_len();
			end
		end
	end

	// Long result stall once traffic is flowing. The sender drops its gaps
	// meanwhile, so snapshots pile up and byte_in has to back up.
	initial begin : long_stall
		wait (bytes_accepted >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// every accepted result beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.encoding, result_if.prefix_skip);
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int drain;
		arst_n            <= 1'b0;
		byte_if.valid     <= 1'b0;
		byte_if.data_byte <= 8'h00;
		byte_if.last_byte <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed buffers
		text_q = '{8'hFF, 8'hFE, 8'h41};  send_text();  // UTF-16LE mark
		text_q = '{8'hEF, 8'hBB, 8'hBF};  send_text();  // UTF-8 mark only
		text_q = '{8'hFF};                send_text();  // one byte, bad everywhere
		text_q = '{8'hC3, 8'hA9};         send_text();  // plain 2-byte UTF-8
		text_q = '{8'hE0, 8'h80};         send_text();  // overlong 3-byte form
		text_q = '{8'hED, 8'hA0, 8'h80};  send_text();  // surrogate
		text_q = '{8'hF4, 8'h90};         send_text();  // above U+10FFFF, open at end
		text_q = '{8'hF0, 8'h8F};         send_text();  // overlong 4-byte form
		text_q = '{8'h82, 8'hA0};         send_text();  // lead/trail pair
		text_q = '{8'hB1};                send_text();  // kana, Korean lead open
		text_q = '{8'h81, 8'h00};         send_text();  // bad trail, re-examined
		text_q = '{8'h88};                send_text();  // lead open at end
		text_q = '{8'hB0, 8'h5A};         send_text();  // kana vs Korean pair

		// random buffers
		while (bytes_accepted < RANDOM_BYTES) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			make_random_text();
			send_text();
		end
		byte_if.valid <= 1'b0;

		// drain, then keep the clock running to catch stray result beats
		drain = 0;
		while (sb.pending() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected result beats never arrived", sb.pending());
			sb.failures++;
		end

		if (sb.failures == 0)
			$display("text_code_page_detector_core_tb passed");
		else
			$display("text_code_page_detector_core_tb failed");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#1_000_000;
		$display("text_code_page_detector_core_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/tcpd_pkg.sv
rtl/core/tcpd_if.sv
rtl/core/tcpd_utf8_check.sv
rtl/core/tcpd_sjis_check.sv
rtl/core/tcpd_cp949_check.sv
rtl/core/tcpd_decide.sv
rtl/core/text_code_page_detector_core.sv
tb/sv/text_code_page_detector_core_tb.sv
